// File: rtl/lrr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_pkg: shared types for the line and rectangle rasterizer
// Command codes and the control group passed from the top level to the core.
// ----------------------------------------------------------------------------
package lrr_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_LINE = 2'd0,
        CMD_LOAD_RECT = 2'd1,
        CMD_STEP      = 2'd2,
        CMD_UNUSED    = 2'd3
    } t_cmd_e;

    // Rectangle sides, clockwise from the origin
    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_BOTTOM = 2'd2,
        SIDE_LEFT   = 2'd3
    } t_side_e;

    typedef struct packed {
        logic load_line;
        logic load_rect;
        logic step;
    } t_ctrl;

endpackage

// File: rtl/lrr_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_cmd_if: command channel
// Valid/ready channel carrying one command item per handshake.
// ----------------------------------------------------------------------------
interface lrr_cmd_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   command;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x_or_width;
    logic signed [COORD_BITS-1:0] end_y_or_height;
    logic [23:0]                  draw_color;

    modport source (
        output valid, command, start_x, start_y, end_x_or_width, end_y_or_height,
               draw_color,
        input  ready
    );
    modport sink (
        input  valid, command, start_x, start_y, end_x_or_width, end_y_or_height,
               draw_color,
        output ready
    );
endinterface

// File: rtl/lrr_pix_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_pix_if: pixel channel
// Valid/ready channel carrying one plotted pixel item per handshake.
// ----------------------------------------------------------------------------
interface lrr_pix_if #(
    parameter int COORD_BITS = 16
);
    logic                       valid;
    logic                       ready;
    logic signed [COORD_BITS:0] pixel_x;
    logic signed [COORD_BITS:0] pixel_y;
    logic [23:0]                pixel_color;
    logic                       shape_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, shape_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, shape_done,
        output ready
    );
endinterface

// File: rtl/lrr_line_setup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_line_setup: Bresenham line setup
// Absolute deltas, step directions and initial error term for one segment.
// ----------------------------------------------------------------------------
module lrr_line_setup #(
    parameter int COORD_BITS = 16
) (
    input  logic signed [COORD_BITS:0]   i_x0,
    input  logic signed [COORD_BITS:0]   i_y0,
    input  logic signed [COORD_BITS:0]   i_x1,
    input  logic signed [COORD_BITS:0]   i_y1,
    output logic [COORD_BITS+1:0]        o_dx,
    output logic [COORD_BITS+1:0]        o_dy,
    output logic                         o_sx,
    output logic                         o_sy,
    output logic signed [COORD_BITS+3:0] o_err
);
    localparam int DW = COORD_BITS + 2;
    localparam int EW = COORD_BITS + 4;

    logic signed [DW-1:0] w_ddx;
    logic signed [DW-1:0] w_ddy;

    assign w_ddx = DW'(i_x1) - DW'(i_x0);
    assign w_ddy = DW'(i_y1) - DW'(i_y0);

    assign o_sx = w_ddx[DW-1];
    assign o_sy = w_ddy[DW-1];
    assign o_dx = w_ddx[DW-1] ? DW'(-w_ddx) : DW'(w_ddx);
    assign o_dy = w_ddy[DW-1] ? DW'(-w_ddy) : DW'(w_ddy);

    assign o_err = $signed({{(EW-DW){1'b0}}, o_dx}) - $signed({{(EW-DW){1'b0}}, o_dy});

endmodule

// File: rtl/lrr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrr_core: shape state and Bresenham stepper
// Holds the loaded shape, presents the current pixel on a step and advances.
// ----------------------------------------------------------------------------
module lrr_core import lrr_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctrl                        i_ctrl,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_end_x_or_width,
    input  logic signed [COORD_BITS-1:0] i_end_y_or_height,
    input  logic [23:0]                  i_draw_color,
    output logic                         o_res_valid,
    output logic signed [COORD_BITS:0]   o_pixel_x,
    output logic signed [COORD_BITS:0]   o_pixel_y,
    output logic [23:0]                  o_pixel_color,
    output logic                         o_shape_done
);
    localparam int PW = COORD_BITS + 1;
    localparam int DW = COORD_BITS + 2;
    localparam int EW = COORD_BITS + 4;

    logic                 r_busy;
    logic                 r_rect_mode;
    t_side_e              r_side;
    logic signed [PW-1:0] r_cx1, r_cy1, r_cx2, r_cy2;
    logic signed [PW-1:0] r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic [DW-1:0]        r_dx, r_dy;
    logic                 r_sx, r_sy;
    logic signed [EW-1:0] r_err;
    logic [23:0]          r_color;

    logic                 n_busy;
    logic                 n_rect_mode;
    t_side_e              n_side;
    logic signed [PW-1:0] n_cx1, n_cy1, n_cx2, n_cy2;
    logic signed [PW-1:0] n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    logic [DW-1:0]        n_dx, n_dy;
    logic                 n_sx, n_sy;
    logic signed [EW-1:0] n_err;
    logic [23:0]          n_color;

    logic signed [PW-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [PW-1:0] w_x0, w_y0, w_x1, w_y1;
    logic [DW-1:0]        w_dx, w_dy;
    logic                 w_sx, w_sy;
    logic signed [EW-1:0] w_err;
    logic                 w_at_target;
    logic                 w_next_side;
    t_side_e              w_side_sel;
    logic signed [EW:0]   w_e2, w_neg_dy, w_dx_e;
    logic signed [EW-1:0] w_dx_ee, w_dy_ee;
    logic                 w_mv_x, w_mv_y;

    assign w_ax = PW'(i_start_x);
    assign w_ay = PW'(i_start_y);
    assign w_bx = PW'(i_end_x_or_width);
    assign w_by = PW'(i_end_y_or_height);

    assign w_at_target = (r_cur_x == r_tgt_x) && (r_cur_y == r_tgt_y);
    assign w_next_side = r_rect_mode && (r_side != SIDE_LEFT);
    assign w_side_sel  = t_side_e'(r_side + 2'd1);

    // Segment endpoints: new line, top side of a new rectangle, or next side
    always_comb begin
        if (i_ctrl.load_line) begin
            w_x0 = w_ax;
            w_y0 = w_ay;
            w_x1 = w_bx;
            w_y1 = w_by;
        end else if (i_ctrl.load_rect) begin
            w_x0 = w_ax;
            w_y0 = w_ay;
            w_x1 = w_ax + w_bx;
            w_y1 = w_ay;
        end else begin
            unique case (w_side_sel)
                SIDE_TOP: begin
                    w_x0 = r_cx1; w_y0 = r_cy1; w_x1 = r_cx2; w_y1 = r_cy1;
                end
                SIDE_RIGHT: begin
                    w_x0 = r_cx2; w_y0 = r_cy1; w_x1 = r_cx2; w_y1 = r_cy2;
                end
                SIDE_BOTTOM: begin
                    w_x0 = r_cx2; w_y0 = r_cy2; w_x1 = r_cx1; w_y1 = r_cy2;
                end
                SIDE_LEFT: begin
                    w_x0 = r_cx1; w_y0 = r_cy2; w_x1 = r_cx1; w_y1 = r_cy1;
                end
            endcase
        end
    end

    lrr_line_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_x0  (w_x0),
        .i_y0  (w_y0),
        .i_x1  (w_x1),
        .i_y1  (w_y1),
        .o_dx  (w_dx),
        .o_dy  (w_dy),
        .o_sx  (w_sx),
        .o_sy  (w_sy),
        .o_err (w_err)
    );

    // One Bresenham update
    assign w_e2     = {r_err, 1'b0};
    assign w_dx_e   = $signed({{(EW+1-DW){1'b0}}, r_dx});
    assign w_neg_dy = -$signed({{(EW+1-DW){1'b0}}, r_dy});
    assign w_dx_ee  = $signed({{(EW-DW){1'b0}}, r_dx});
    assign w_dy_ee  = $signed({{(EW-DW){1'b0}}, r_dy});
    assign w_mv_x   = w_e2 > w_neg_dy;
    assign w_mv_y   = w_e2 < w_dx_e;

    always_comb begin
        n_busy      = r_busy;
        n_rect_mode = r_rect_mode;
        n_side      = r_side;
        n_cx1       = r_cx1;
        n_cy1       = r_cy1;
        n_cx2       = r_cx2;
        n_cy2       = r_cy2;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_tgt_x     = r_tgt_x;
        n_tgt_y     = r_tgt_y;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_err       = r_err;
        n_color     = r_color;
        if (i_ctrl.load_line || i_ctrl.load_rect) begin
            n_busy      = 1'b1;
            n_rect_mode = i_ctrl.load_rect;
            n_side      = SIDE_TOP;
            n_color     = i_draw_color;
            if (i_ctrl.load_rect) begin
                n_cx1 = w_ax;
                n_cy1 = w_ay;
                n_cx2 = w_ax + w_bx;
                n_cy2 = w_ay + w_by;
            end
        end else if (i_ctrl.step && r_busy && w_at_target) begin
            if (w_next_side) begin
                n_side = w_side_sel;
            end else begin
                n_busy = 1'b0;
            end
        end else if (i_ctrl.step && r_busy) begin
            n_err = r_err - (w_mv_x ? w_dy_ee : EW'(0)) + (w_mv_y ? w_dx_ee : EW'(0));
            if (w_mv_x) begin
                n_cur_x = r_cur_x + (r_sx ? {PW{1'b1}} : PW'(1));
            end
            if (w_mv_y) begin
                n_cur_y = r_cur_y + (r_sy ? {PW{1'b1}} : PW'(1));
            end
        end
        // Load a fresh segment on a new shape or at a rectangle corner
        if (i_ctrl.load_line || i_ctrl.load_rect ||
            (i_ctrl.step && r_busy && w_at_target && w_next_side)) begin
            n_cur_x = w_x0;
            n_cur_y = w_y0;
            n_tgt_x = w_x1;
            n_tgt_y = w_y1;
            n_dx    = w_dx;
            n_dy    = w_dy;
            n_sx    = w_sx;
            n_sy    = w_sy;
            n_err   = w_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_rect_mode <= 1'b0;
            r_side      <= SIDE_TOP;
            r_cx1       <= '0;
            r_cy1       <= '0;
            r_cx2       <= '0;
            r_cy2       <= '0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_tgt_x     <= '0;
            r_tgt_y     <= '0;
            r_dx        <= '0;
            r_dy        <= '0;
            r_sx        <= 1'b0;
            r_sy        <= 1'b0;
            r_err       <= '0;
            r_color     <= '0;
        end else begin
            r_busy      <= n_busy;
            r_rect_mode <= n_rect_mode;
            r_side      <= n_side;
            r_cx1       <= n_cx1;
            r_cy1       <= n_cy1;
            r_cx2       <= n_cx2;
            r_cy2       <= n_cy2;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_tgt_x     <= n_tgt_x;
            r_tgt_y     <= n_tgt_y;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_sx        <= n_sx;
            r_sy        <= n_sy;
            r_err       <= n_err;
            r_color     <= n_color;
        end
    end

    assign o_res_valid   = i_ctrl.step && r_busy;
    assign o_pixel_x     = r_cur_x;
    assign o_pixel_y     = r_cur_y;
    assign o_pixel_color = r_color;
    assign o_shape_done  = w_at_target && !w_next_side;

    a_done_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_shape_done) |=> !r_busy)
        else $error("core still busy after final pixel");

    a_line_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rect_mode |-> (r_side == SIDE_TOP))
        else $error("side index moved while tracing a line");

    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctrl.load_line || i_ctrl.load_rect) |=> (r_busy && r_side == SIDE_TOP))
        else $error("load did not start a new shape");

endmodule

// File: rtl/line_and_rect_rasterizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_and_rect_rasterizer_top: line and rectangle outline rasterizer
// Command decode, Bresenham core and registered pixel output.
// ----------------------------------------------------------------------------
// Takes one command item per clock while the pixel sink keeps up. Load-line and
// load-rectangle commands latch a shape and give no pixel; each step command
// while a shape is active gives one pixel item in the next cycle, so a shape
// streams out at one pixel per clock with steps issued back to back and no sink
// stall. The figure is set by the core's Bresenham update (one add and compare
// per axis) feeding one output register; the command side stalls only while
// that register holds a pixel the sink has not taken. Rectangles emit four
// sides clockwise, so each corner appears twice; shape_done marks the final pixel.
module line_and_rect_rasterizer_top import lrr_pkg::*; #(
    parameter int COORD_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lrr_cmd_if.sink   i_cmd,
    lrr_pix_if.source o_pix
);
    localparam int PW = COORD_BITS + 1;

    t_ctrl                w_ctrl;
    t_cmd_e               w_cmd;
    logic                 w_in_acc;
    logic                 w_res_valid;
    logic signed [PW-1:0] w_px, w_py;
    logic [23:0]          w_pcolor;
    logic                 w_pdone;

    logic                 r_out_valid, n_out_valid;
    logic signed [PW-1:0] r_out_x, r_out_y;
    logic [23:0]          r_out_color;
    logic                 r_out_done;

    assign i_cmd.ready = !r_out_valid || o_pix.ready;
    assign w_in_acc    = i_cmd.valid && i_cmd.ready;
    assign w_cmd       = t_cmd_e'(i_cmd.command);

    always_comb begin
        w_ctrl = '0;
        if (w_in_acc) begin
            unique case (w_cmd)
                CMD_LOAD_LINE: w_ctrl.load_line = 1'b1;
                CMD_LOAD_RECT: w_ctrl.load_rect = 1'b1;
                CMD_STEP:      w_ctrl.step      = 1'b1;
                CMD_UNUSED:    w_ctrl           = '0;
            endcase
        end
    end

    lrr_core #(
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (w_ctrl),
        .i_start_x         (i_cmd.start_x),
        .i_start_y         (i_cmd.start_y),
        .i_end_x_or_width  (i_cmd.end_x_or_width),
        .i_end_y_or_height (i_cmd.end_y_or_height),
        .i_draw_color      (i_cmd.draw_color),
        .o_res_valid       (w_res_valid),
        .o_pixel_x         (w_px),
        .o_pixel_y         (w_py),
        .o_pixel_color     (w_pcolor),
        .o_shape_done      (w_pdone)
    );

    // Hold the pixel until taken; a new item lands only when the slot frees
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_res_valid) begin
            n_out_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out_x     <= w_px;
            r_out_y     <= w_py;
            r_out_color <= w_pcolor;
            r_out_done  <= w_pdone;
        end
    end

    assign o_pix.valid       = r_out_valid;
    assign o_pix.pixel_x     = r_out_x;
    assign o_pix.pixel_y     = r_out_y;
    assign o_pix.pixel_color = r_out_color;
    assign o_pix.shape_done  = r_out_done;

    a_pixel_from_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> $past(w_in_acc && w_cmd == CMD_STEP))
        else $error("pixel appeared without a step command");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_pix.ready) |-> !w_res_valid)
        else $error("pending pixel overwritten");

endmodule

// File: tb/sv/line_and_rect_rasterizer_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_and_rect_rasterizer_top_tb: pixel stream check of the rasterizer
// A short table of commands at the coordinate extremes comes first. Random
// lines and rectangle outlines follow, stepped to the end or cut short by a
// reload, mixed with noise commands. Each pixel item is compared field by
// field against a behavioral Bresenham tracer, with random gaps on the
// command side and random stalls on the pixel side.
// ----------------------------------------------------------------------------
module line_and_rect_rasterizer_top_tb;
    import lrr_pkg::*;

    localparam int CB           = 16;
    localparam int COORD_MAX    = 2 ** (CB - 1) - 1;
    localparam int COORD_MIN    = -(2 ** (CB - 1));
    localparam int RANDOM_ITEMS = 1700;
    localparam int QUIET_LIMIT  = 2000;
    localparam int N_DIR        = 27;

    typedef logic signed [CB:0] t_pix;

    typedef struct packed {
        t_cmd_e                 command;
        logic signed [CB-1:0]   sx;
        logic signed [CB-1:0]   sy;
        logic signed [CB-1:0]   ex;
        logic signed [CB-1:0]   ey;
        logic [23:0]            color;
    } t_cmd_item;

    typedef struct packed {
        logic signed [CB:0] x;
        logic signed [CB:0] y;
        logic [23:0]        color;
        logic               done;
    } t_pixel;

    typedef struct packed {
        bit     typed;
        t_pixel want;
    } t_pixel_note;

    typedef struct packed {
        t_cmd_item item;
        bit        typed;
        t_pixel    want;
    } t_cmd_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lrr_cmd_if #(.COORD_BITS(CB)) cmd_if ();
    lrr_pix_if #(.COORD_BITS(CB)) pix_if ();

    line_and_rect_rasterizer_top #(
        .COORD_BITS(CB)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_pix   (pix_if)
    );

    always #4 i_clk = ~i_clk;

    // Directed table: pixels typed in only where they are plain to see
    t_cmd_row dir_rows [N_DIR] = '{
        '{'{CMD_STEP,      0, 0, 0, 0, 24'h000000}, 1'b0, '{0, 0, 0, 0}},
        '{'{CMD_LOAD_LINE, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 24'hFFFFFF},
            1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{32767, -32768, 24'hFFFFFF, 1'b1}},
        '{'{CMD_LOAD_LINE, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 24'h000000},
            1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{-32768, 32767, 24'h000000, 1'b1}},
        '{'{CMD_LOAD_RECT, 0, 0, 0, 0, 24'h123456}, 1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{0, 0, 24'h123456, 1'b0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{0, 0, 24'h123456, 1'b0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{0, 0, 24'h123456, 1'b0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{0, 0, 24'h123456, 1'b1}},
        '{'{CMD_LOAD_LINE, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 24'hAAAAAA},
            1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{-32768, -32768, 24'hAAAAAA, 1'b0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{-32767, -32767, 24'hAAAAAA, 1'b0}},
        // reload while the long line is still being traced
        '{'{CMD_LOAD_RECT, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 24'h555555},
            1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{32767, 32767, 24'h555555, 1'b0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{32768, 32767, 24'h555555, 1'b0}},
        '{'{CMD_LOAD_RECT, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 24'h0F0F0F},
            1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{-32768, -32768, 24'h0F0F0F, 1'b0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b1, '{-32769, -32768, 24'h0F0F0F, 1'b0}},
        '{'{CMD_UNUSED,    16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 24'hFFFFFF},
            1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{CMD_LOAD_LINE, 0, 0, 2, -3, 24'hC0FFEE}, 1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}},
        '{'{CMD_STEP,      0, 0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}}
    };

    // Tracer state
    bit               tracing   = 1'b0;
    bit               rect_on   = 1'b0;
    t_side_e          side      = SIDE_TOP;
    t_pix             corner [4] = '{default: '0};
    t_pix             cur_x     = '0;
    t_pix             cur_y     = '0;
    t_pix             tgt_x     = '0;
    t_pix             tgt_y     = '0;
    logic [CB+1:0]    run_x     = '0;
    logic [CB+1:0]    run_y     = '0;
    bit               back_x    = 1'b0;
    bit               back_y    = 1'b0;
    logic signed [CB+3:0] bres_err = '0;
    logic [23:0]      shape_col = '0;

    t_pixel      pixel_q [$];
    t_pixel_note note_q [$];
    int          n_errors     = 0;
    int          quiet_cycles = 0;
    int          hold_cycles  = 0;
    bit          gaps_on      = 1'b1;

    function automatic void aim_segment(t_pix x0, t_pix y0, t_pix x1, t_pix y1);
        cur_x    = x0;
        cur_y    = y0;
        tgt_x    = x1;
        tgt_y    = y1;
        run_x    = (x1 >= x0) ? x1 - x0 : x0 - x1;
        run_y    = (y1 >= y0) ? y1 - y0 : y0 - y1;
        back_x   = x1 < x0;
        back_y   = y1 < y0;
        bres_err = run_x - run_y;
    endfunction

    function automatic void aim_side(t_side_e s);
        case (s)
            SIDE_TOP:    aim_segment(corner[0], corner[1], corner[2], corner[1]);
            SIDE_RIGHT:  aim_segment(corner[2], corner[1], corner[2], corner[3]);
            SIDE_BOTTOM: aim_segment(corner[2], corner[3], corner[0], corner[3]);
            default:     aim_segment(corner[0], corner[3], corner[0], corner[1]);
        endcase
    endfunction

    // Advance the tracer by one command; returns 1 when a pixel comes out
    function automatic bit trace_item(input t_cmd_item it, output t_pixel px);
        longint twice_err;
        px = '0;
        if (it.command == CMD_LOAD_LINE || it.command == CMD_LOAD_RECT) begin
            shape_col = it.color;
            tracing   = 1'b1;
            side      = SIDE_TOP;
            if (it.command == CMD_LOAD_LINE) begin
                rect_on = 1'b0;
                aim_segment(it.sx, it.sy, it.ex, it.ey);
            end else begin
                rect_on   = 1'b1;
                corner[0] = it.sx;
                corner[1] = it.sy;
                corner[2] = it.sx + it.ex;
                corner[3] = it.sy + it.ey;
                aim_side(SIDE_TOP);
            end
            return 1'b0;
        end
        if (it.command != CMD_STEP || !tracing)
            return 1'b0;
        px.x     = cur_x;
        px.y     = cur_y;
        px.color = shape_col;
        px.done  = 1'b0;
        if (cur_x == tgt_x && cur_y == tgt_y) begin
            if (rect_on && side != SIDE_LEFT) begin
                side = t_side_e'(side + 2'd1);
                aim_side(side);
            end else begin
                tracing = 1'b0;
                px.done = 1'b1;
            end
        end else begin
            twice_err = 2 * longint'(bres_err);
            if (twice_err > -longint'(run_y)) begin
                bres_err = bres_err - run_y;
                cur_x    = back_x ? cur_x - 1 : cur_x + 1;
            end
            if (twice_err < longint'(run_x)) begin
                bres_err = bres_err + run_x;
                cur_y    = back_y ? cur_y - 1 : cur_y + 1;
            end
        end
        return 1'b1;
    endfunction

    function automatic void note_diff(string what, longint want, longint got);
        if (want != got) begin
            n_errors++;
            $display("%0t: %s expected %0d (0x%0h) got %0d (0x%0h)",
                     $time, what, want, want, got, got);
        end
    endfunction

    // Pick a coordinate near base; fold back inward when it would wrap
    function automatic logic signed [CB-1:0] offset_coord(logic signed [CB-1:0] base,
                                                           int span);
        int far_end;
        far_end = $urandom_range(0, 1) ? int'(base) + span : int'(base) - span;
        if (far_end > COORD_MAX || far_end < COORD_MIN)
            far_end = 2 * int'(base) - far_end;
        return far_end[CB-1:0];
    endfunction

    task automatic send_item(t_cmd_item it, bit typed, t_pixel want);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        note_q.push_back('{typed, want});
        cmd_if.valid           <= 1'b1;
        cmd_if.command         <= it.command;
        cmd_if.start_x         <= it.sx;
        cmd_if.start_y         <= it.sy;
        cmd_if.end_x_or_width  <= it.ex;
        cmd_if.end_y_or_height <= it.ey;
        cmd_if.draw_color      <= it.color;
        do
            @(posedge i_clk);
        while (!cmd_if.ready);
        @(negedge i_clk);
    endtask

    // Pixel side: random stall bursts
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            pix_if.ready <= 1'b0;
            hold_cycles  <= hold_cycles - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            pix_if.ready <= 1'b0;
            hold_cycles  <= $urandom_range(0, 12);
        end else begin
            pix_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : pixel_monitor
        t_cmd_item   seen;
        t_pixel      traced;
        t_pixel      want_px;
        t_pixel_note note;
        if (i_rst_n) begin
            if (pix_if.valid && pix_if.ready) begin
                if (pixel_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: pixel expected none got (%0d, %0d) 0x%0h done %0b",
                             $time, pix_if.pixel_x, pix_if.pixel_y,
                             pix_if.pixel_color, pix_if.shape_done);
                end else begin
                    want_px = pixel_q.pop_front();
                    note_diff("pixel_x", want_px.x, pix_if.pixel_x);
                    note_diff("pixel_y", want_px.y, pix_if.pixel_y);
                    note_diff("pixel_color", want_px.color, pix_if.pixel_color);
                    note_diff("shape_done", want_px.done, pix_if.shape_done);
                end
            end
            if (cmd_if.valid && cmd_if.ready) begin
                seen.command = t_cmd_e'(cmd_if.command);
                seen.sx      = cmd_if.start_x;
                seen.sy      = cmd_if.start_y;
                seen.ex      = cmd_if.end_x_or_width;
                seen.ey      = cmd_if.end_y_or_height;
                seen.color   = cmd_if.draw_color;
                note         = note_q.pop_front();
                if (trace_item(seen, traced))
                    pixel_q.push_back(note.typed ? note.want : traced);
            end
        end
    end

    // Watchdog: end the run after too long without any item moving
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin : stimulus
        t_cmd_item it;
        t_cmd_item step_it;
        int        n_sent;
        int        pick;
        int        span_x;
        int        span_y;
        int        n_steps;
        bit        calm;
        n_sent                 = 0;
        calm                   = 1'b0;
        i_rst_n                = 1'b0;
        pix_if.ready           = 1'b0;
        cmd_if.valid           = 1'b0;
        cmd_if.command         = CMD_STEP;
        cmd_if.start_x         = '0;
        cmd_if.start_y         = '0;
        cmd_if.end_x_or_width  = '0;
        cmd_if.end_y_or_height = '0;
        cmd_if.draw_color      = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k])
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);

        while (n_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0)
                calm = !calm;
            // no idling at all in the closing stretch
            gaps_on  = !calm && (n_sent < RANDOM_ITEMS - 300);
            pick     = $urandom_range(0, 99);
            it.color = 24'($urandom);
            it.sx    = CB'($urandom);
            it.sy    = CB'($urandom);
            if (pick < 45) begin
                it.command = CMD_LOAD_LINE;
                span_x     = $urandom_range(0, 12);
                span_y     = $urandom_range(0, 12);
                it.ex      = offset_coord(it.sx, span_x);
                it.ey      = offset_coord(it.sy, span_y);
                n_steps    = (span_x > span_y ? span_x : span_y) + 1;
            end else if (pick < 80) begin
                it.command = CMD_LOAD_RECT;
                span_x     = $urandom_range(0, 6);
                span_y     = $urandom_range(0, 6);
                it.ex      = CB'($urandom_range(0, 1) ? span_x : -span_x);
                it.ey      = CB'($urandom_range(0, 1) ? span_y : -span_y);
                n_steps    = 2 * (span_x + 1) + 2 * (span_y + 1);
            end else if (pick < 92) begin
                // long shapes: trace only the first few pixels
                it.command = $urandom_range(0, 1) ? CMD_LOAD_RECT : CMD_LOAD_LINE;
                it.ex      = CB'($urandom);
                it.ey      = CB'($urandom);
                n_steps    = $urandom_range(1, 6);
            end else begin
                it.command = t_cmd_e'($urandom_range(0, 3));
                it.ex      = CB'($urandom);
                it.ey      = CB'($urandom);
                n_steps    = 0;
            end
            // now and then cut the shape short so the next load replaces it
            if ($urandom_range(0, 9) == 0)
                n_steps = $urandom_range(0, n_steps);
            else
                n_steps += $urandom_range(0, 2);
            send_item(it, 1'b0, '0);
            if (it.command != CMD_UNUSED)
                n_sent++;
            repeat (n_steps) begin
                step_it.command = CMD_STEP;
                step_it.sx      = CB'($urandom);
                step_it.sy      = CB'($urandom);
                step_it.ex      = CB'($urandom);
                step_it.ey      = CB'($urandom);
                step_it.color   = 24'($urandom);
                send_item(step_it, 1'b0, '0);
                n_sent++;
            end
        end
        cmd_if.valid <= 1'b0;

        while (pixel_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
